FILE: rtl/bdq_pkg.sv
// Package for the bounded deque core.
// Opcode and status codes, controller state encoding, datapath command word.
// No dependencies.
package bdq_pkg;

  localparam int OPCODE_WIDTH   = 3;
  localparam int STATUS_WIDTH   = 2;
  localparam int POSITION_WIDTH = 8;

  localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_WIDTH-1:0] OP_READ_FRONT = 3'd4;
  localparam logic [OPCODE_WIDTH-1:0] OP_READ_BACK  = 3'd5;
  localparam logic [OPCODE_WIDTH-1:0] OP_READ_AT    = 3'd6;
  localparam logic [OPCODE_WIDTH-1:0] OP_STATUS     = 3'd7;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dp_cmd_t;

endpackage

FILE: rtl/bdq_in_if.sv
// Input channel of the bounded deque core: valid/ready plus one request word.
// Depends on bdq_pkg.
interface bdq_in_if
  import bdq_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
);
  logic                      valid;
  logic                      ready;
  logic [OPCODE_WIDTH-1:0]   opcode;
  logic [VALUE_WIDTH-1:0]    push_value;
  logic [POSITION_WIDTH-1:0] position;

  modport source (output valid, output opcode, output push_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input push_value, input position,
                  output ready);
endinterface

FILE: rtl/bdq_out_if.sv
// Result channel of the bounded deque core: valid/ready plus one result word.
// Depends on bdq_pkg.
interface bdq_out_if
  import bdq_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 5
);
  logic                    valid;
  logic                    ready;
  logic [VALUE_WIDTH-1:0]  read_value;
  logic [STATUS_WIDTH-1:0] status;
  logic [COUNT_WIDTH-1:0]  entry_count;
  logic                    is_empty;

  modport source (output valid, output read_value, output status, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  input is_empty, output ready);
endinterface

FILE: rtl/bounded_deque_with_index_read_core.sv
// Bounded deque core: push/pop at both ends, read front/back/at position.
// Each word is captured, then executed (store access), then loaded into the result register;
// the load waits while the output stalls, and a new word is taken only back in idle.
// A new word is taken while the previous result still waits on the output.
// Reset (synchronous, rst_n low): queue empty, front pointer 0, no result pending.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if, bdq_ctrl, bdq_dp.
module bounded_deque_with_index_read_core
  import bdq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
)(
  input  logic             clk,
  input  logic             rst_n,
  bdq_in_if.sink           in_ch,
  bdq_out_if.source        out_ch
);

  localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

  dp_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bdq_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_ch.opcode),
    .in_push_value   (in_ch.push_value),
    .in_position     (in_ch.position),
    .out_read_value  (out_ch.read_value),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty)
  );

endmodule

FILE: rtl/bdq_ctrl.sv
// Controller for the bounded deque core: capture / execute / load sequencing
// and ownership of the result valid flag. Depends on bdq_pkg.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    cmd.capture = in_ready & in_valid;
    cmd.exec    = (state_r == S_EXEC);
    cmd.load    = (state_r == S_LOAD) & (~out_valid_r | out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_LOAD;
      S_LOAD: if (cmd.load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/bdq_dp.sv
// Datapath for the bounded deque core: circular store, front pointer, count,
// slot address wrap and the result register. Depends on bdq_pkg.
module bdq_dp
  import bdq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 5
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  input  logic [OPCODE_WIDTH-1:0]   in_opcode,
  input  logic [VALUE_WIDTH-1:0]    in_push_value,
  input  logic [POSITION_WIDTH-1:0] in_position,
  output logic [VALUE_WIDTH-1:0]    out_read_value,
  output logic [STATUS_WIDTH-1:0]   out_status,
  output logic [COUNT_WIDTH-1:0]    out_entry_count,
  output logic                      out_is_empty
);

  localparam int PW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int SW = ((COUNT_WIDTH > POSITION_WIDTH) ? COUNT_WIDTH : POSITION_WIDTH) + 1;

  logic [OPCODE_WIDTH-1:0]   op_r;
  logic [VALUE_WIDTH-1:0]    val_r;
  logic [POSITION_WIDTH-1:0] pos_r;

  logic [PW-1:0]          front_r, front_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] mem_rd_r;
  logic                   rsel_r, rsel_nxt;
  logic [STATUS_WIDTH-1:0] st_r, st_nxt;

  logic [VALUE_WIDTH-1:0]  out_value_r;
  logic [STATUS_WIDTH-1:0] out_status_r;
  logic [COUNT_WIDTH-1:0]  out_count_r;
  logic                    out_empty_r;

  logic          full, empty, we, use_front_dec;
  logic [SW-1:0] off, sum, wrapped;
  logic [PW-1:0] front_dec, front_inc, addr;

  always_comb begin
    full      = (count_r == COUNT_WIDTH'(CAPACITY));
    empty     = (count_r == '0);
    front_dec = (front_r == '0) ? PW'(CAPACITY - 1) : front_r - 1'b1;
    front_inc = (front_r == PW'(CAPACITY - 1)) ? '0 : front_r + 1'b1;

    off           = '0;
    we            = 1'b0;
    use_front_dec = 1'b0;
    rsel_nxt      = 1'b0;
    st_nxt        = ST_OK;
    front_nxt     = front_r;
    count_nxt     = count_r;

    case (op_r)
      OP_PUSH_BACK: begin
        off = SW'(count_r);
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        use_front_dec = 1'b1;
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_BACK: begin
        off = SW'(count_r - 1'b1);
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          rsel_nxt  = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          rsel_nxt  = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_READ_FRONT: begin
        if (empty) st_nxt = ST_EMPTY;
        else rsel_nxt = 1'b1;
      end
      OP_READ_BACK: begin
        off = SW'(count_r - 1'b1);
        if (empty) st_nxt = ST_EMPTY;
        else rsel_nxt = 1'b1;
      end
      OP_READ_AT: begin
        off = SW'(pos_r);
        if (SW'(pos_r) >= SW'(count_r)) st_nxt = ST_EMPTY;
        else rsel_nxt = 1'b1;
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase

    sum     = SW'(front_r) + off;
    wrapped = (sum >= SW'(CAPACITY)) ? sum - SW'(CAPACITY) : sum;
    addr    = use_front_dec ? front_dec : wrapped[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      val_r <= in_push_value;
      pos_r <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (we) mem[addr] <= val_r;
      mem_rd_r <= mem[addr];
      rsel_r   <= rsel_nxt;
      st_r     <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_value_r  <= rsel_r ? mem_rd_r : '0;
      out_status_r <= st_r;
      out_count_r  <= count_r;
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_read_value  = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;

endmodule

FILE: rtl/bdq_checker.sv
// Port-level checks for the bounded deque core, bound to the top level.
// Depends on bdq_pkg.
module bdq_checker
  import bdq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 5
)(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [VALUE_WIDTH-1:0]  read_value,
  input logic [STATUS_WIDTH-1:0] status,
  input logic [COUNT_WIDTH-1:0]  entry_count,
  input logic                    is_empty
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> entry_count == COUNT_WIDTH'(CAPACITY))
    else $error("full status with room left");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= COUNT_WIDTH'(CAPACITY))
    else $error("count exceeds capacity");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> read_value == '0)
    else $error("nonzero value on failed operation");

endmodule

bind bounded_deque_with_index_read_core bdq_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_bdq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .read_value  (out_ch.read_value),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count),
  .is_empty    (out_ch.is_empty)
);

FILE: tb/tb_bounded_deque_with_index_read_core.sv
// Testbench for bounded_deque_with_index_read_core: directed empty/full corner words,
// then biased random traffic with random idling on both channels, scored against a mirror.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if and the core.
`timescale 1ns / 1ps

module tb_bounded_deque_with_index_read_core;
  import bdq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 5;
  localparam int CYCLE_CAP  = 400000;
  localparam int PRINT_CAP  = 40;

  typedef struct {
    logic [OPCODE_WIDTH-1:0] op;
    logic [VAL_W-1:0]        read_value;
    logic [STATUS_WIDTH-1:0] status;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
  } deque_result_t;

  logic clk;
  logic rst_n;

  bdq_in_if  #(.VALUE_WIDTH(VAL_W))                     in_ch ();
  bdq_out_if #(.VALUE_WIDTH(VAL_W), .COUNT_WIDTH(CNT_W)) out_ch ();

  bounded_deque_with_index_read_core #(
    .CAPACITY    (DEPTH),
    .VALUE_WIDTH (VAL_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the deque
  logic [VAL_W-1:0] mirror_slots [DEPTH];
  logic [3:0]       mirror_front;
  logic [CNT_W-1:0] mirror_count;

  deque_result_t pending_results[$];

  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned full_hits;
  int unsigned miss_hits;
  int unsigned peak_depth;
  int unsigned cycle_count;
  bit          src_calm;
  bit          sink_calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("tb_bounded_deque_with_index_read_core NOT OK");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic int unsigned draw_gap(input bit calm);
    if (calm)
      return 0;
    case ($urandom_range(0, 2))
      0: return 0;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [3:0] slot_after_front(input logic [CNT_W-1:0] offset);
    logic [3:0] s;
    s = mirror_front + offset[3:0];
    return s;
  endfunction

  // applies one word to the mirror and returns the result it should produce
  function automatic deque_result_t deque_apply(input logic [OPCODE_WIDTH-1:0] op,
                                                input logic [VAL_W-1:0] val,
                                                input logic [POSITION_WIDTH-1:0] pos);
    deque_result_t r;
    r.op         = op;
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_PUSH_BACK: begin
        if (mirror_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_slots[slot_after_front(mirror_count)] = val;
          mirror_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (mirror_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_front = mirror_front - 4'd1;
          mirror_slots[mirror_front] = val;
          mirror_count++;
        end
      end
      OP_POP_BACK: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = mirror_slots[slot_after_front(mirror_count - 1'b1)];
          mirror_count--;
        end
      end
      OP_POP_FRONT: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = mirror_slots[mirror_front];
          mirror_front = mirror_front + 4'd1;
          mirror_count--;
        end
      end
      OP_READ_FRONT: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else r.read_value = mirror_slots[mirror_front];
      end
      OP_READ_BACK: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else r.read_value = mirror_slots[slot_after_front(mirror_count - 1'b1)];
      end
      OP_READ_AT: begin
        if (pos >= mirror_count) r.status = ST_EMPTY;
        else r.read_value = mirror_slots[slot_after_front(pos[CNT_W-1:0])];
      end
      default: ;
    endcase
    r.entry_count = mirror_count;
    r.is_empty    = (mirror_count == 0);
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_EMPTY) miss_hits++;
    if (mirror_count > peak_depth) peak_depth = mirror_count;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    deque_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          flag_mismatch("result word with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.read_value !== want.read_value)
            flag_mismatch($sformatf("op %0d read_value %h, want %h", want.op,
                                    out_ch.read_value, want.read_value));
          if (out_ch.status !== want.status)
            flag_mismatch($sformatf("op %0d status %0d, want %0d", want.op,
                                    out_ch.status, want.status));
          if (out_ch.entry_count !== want.entry_count)
            flag_mismatch($sformatf("op %0d entry_count %0d, want %0d", want.op,
                                    out_ch.entry_count, want.entry_count));
          if (out_ch.is_empty !== want.is_empty)
            flag_mismatch($sformatf("op %0d is_empty %b, want %b", want.op,
                                    out_ch.is_empty, want.is_empty));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(deque_apply(in_ch.opcode, in_ch.push_value,
                                              in_ch.position));
        words_sent++;
      end
    end
  end

  // result side: random stalls drawn per word
  initial begin
    int unsigned k;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      k = draw_gap(sink_calm);
      if (k > 0) begin
        out_ch.ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // called and returns at a falling edge; valid stays high for back-to-back words
  task automatic send_word(input logic [OPCODE_WIDTH-1:0] op, input logic [VAL_W-1:0] val,
                           input logic [POSITION_WIDTH-1:0] pos);
    int unsigned k;
    k = draw_gap(src_calm);
    if (k > 0) begin
      in_ch.valid <= 1'b0;
      repeat (k) @(negedge clk);
    end
    in_ch.opcode     <= op;
    in_ch.push_value <= val;
    in_ch.position   <= pos;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_ops();
    send_word(OP_POP_BACK,   32'hFFFF_FFFF, 8'h00);
    send_word(OP_POP_FRONT,  32'h0000_0000, 8'hFF);
    send_word(OP_READ_FRONT, 32'hA5A5_A5A5, 8'h00);
    send_word(OP_READ_BACK,  32'h5A5A_5A5A, 8'h00);
    send_word(OP_READ_AT,    32'h0000_0000, 8'h00);
  endtask

  // fill to capacity from both ends (front wraps), overflow, then probe positions
  task automatic test_fill_and_overflow();
    logic [VAL_W-1:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: v = 32'h0000_0000;
        1: v = 32'hFFFF_FFFF;
        2: v = 32'hAAAA_AAAA;
        3: v = 32'h5555_5555;
        default: v = $urandom;
      endcase
      send_word(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, v, 8'($urandom));
    end
    send_word(OP_PUSH_BACK,  32'h1234_5678, 8'h00);
    send_word(OP_PUSH_FRONT, 32'h8765_4321, 8'h00);
    send_word(OP_READ_AT,    32'h0000_0000, 8'd15);
    send_word(OP_READ_AT,    32'h0000_0000, 8'd16);
    send_word(OP_READ_AT,    32'h0000_0000, 8'hFF);
    send_word(OP_STATUS,     32'hFFFF_FFFF, 8'hFF);
  endtask

  // alternating fill-heavy and drain-heavy stretches so the count sweeps 0..16
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned phase_left;
    int unsigned push_pct;
    int unsigned roll;
    bit filling;
    logic [OPCODE_WIDTH-1:0]   op;
    logic [POSITION_WIDTH-1:0] pos;
    phase_left = 0;
    filling    = 1'b0;
    repeat (n_words) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(12, 48);
      end
      phase_left--;
      push_pct = filling ? 60 : 12;
      roll = $urandom_range(0, 99);
      if (roll >= 95) begin
        op = OPCODE_WIDTH'($urandom);
      end else if (roll < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else if (roll < push_pct + 30) begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end else begin
        case ($urandom_range(0, 4))
          0: op = OP_READ_FRONT;
          1: op = OP_READ_BACK;
          4: op = OP_STATUS;
          default: op = OP_READ_AT;
        endcase
      end
      if ($urandom_range(0, 3) == 0) pos = POSITION_WIDTH'($urandom_range(0, 255));
      else pos = POSITION_WIDTH'($urandom_range(0, mirror_count));
      send_word(op, $urandom, pos);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_STATUS;
    in_ch.push_value = '0;
    in_ch.position   = '0;
    mirror_front     = '0;
    mirror_count     = '0;
    for (int i = 0; i < DEPTH; i++) mirror_slots[i] = '0;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_ops();
    test_fill_and_overflow();
    hold_until_drained();

    test_random_traffic(400);
    hold_until_drained();
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    test_random_traffic(250);
    sink_calm = 1'b0;
    test_random_traffic(200);
    hold_until_drained();
    src_calm  = 1'b0;
    sink_calm = 1'b1;
    test_random_traffic(200);
    sink_calm = 1'b0;
    test_random_traffic(200);

    hold_until_drained();
    repeat (10) @(negedge clk);

    $display("%0d words sent, %0d results checked, %0d mismatches", words_sent,
             results_checked, mismatch_count);
    $display("%0d dropped pushes on full, %0d empty/not-found results, peak depth %0d",
             full_hits, miss_hits, peak_depth);
    if (mismatch_count == 0)
      $display("tb_bounded_deque_with_index_read_core OK");
    else
      $display("tb_bounded_deque_with_index_read_core NOT OK");
    $finish;
  end

endmodule
